### rtl/websocket_frame_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent at this edge implies consequent at the next edge.
`define WSDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle property");

// Antecedent implies consequent at the same edge.
`define WSDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle property");

`else

`define WSDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define WSDF_ASSERT_SAME(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/wsdf_pkg.sv
// Types and constants for the WebSocket frame deframer.
// No dependencies.
package wsdf_pkg;

    localparam int unsigned LEN_W = 63;

    // parse phase codes
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_XLEN = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    // 7-bit length escapes
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] XLEN16_BYTES = 4'd2;
    localparam logic [3:0] XLEN64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             fin;
        logic [2:0]       rsv_bits;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       data_byte;
        logic             last;
    } t_result;

endpackage

### rtl/wsdf_parser.sv
// Frame parse state and next-state logic, one byte per commit.
// Depends on wsdf_pkg.
module wsdf_parser
    import wsdf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_commit,
    input  logic [7:0] i_byte,
    output logic    o_has_result,
    output t_result o_result
);

    logic [2:0]       r_phase, n_phase;
    logic [3:0]       r_cnt, n_cnt;
    logic [8:0]       r_flags, n_flags;
    logic [LEN_W-1:0] r_len, n_len;
    logic [31:0]      r_key, n_key;
    logic [1:0]       r_kidx, n_kidx;

    logic [LEN_W-1:0] len_shift;
    logic [LEN_W-1:0] hdr_len;
    logic [7:0]       key_byte;
    logic             data_last;
    logic             hdr_done;

    assign len_shift = {r_len[LEN_W-9:0], i_byte};

    always_comb begin
        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // final payload byte when at most one byte is left
    assign data_last = (r_len[LEN_W-1:1] == '0);

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_flags  = r_flags;
        n_len    = r_len;
        n_key    = r_key;
        n_kidx   = r_kidx;
        hdr_done = 1'b0;
        hdr_len  = r_len;
        o_has_result = 1'b0;
        o_result = '0;

        unique case (r_phase)
            PH_HDR1: begin
                n_flags[0] = i_byte[7];
                if (i_byte[6:0] == LEN7_EXT16) begin
                    n_len   = '0;
                    n_cnt   = XLEN16_BYTES;
                    n_phase = PH_XLEN;
                end else if (i_byte[6:0] == LEN7_EXT64) begin
                    n_len   = '0;
                    n_cnt   = XLEN64_BYTES;
                    n_phase = PH_XLEN;
                end else begin
                    n_len   = {{(LEN_W-7){1'b0}}, i_byte[6:0]};
                    hdr_len = n_len;
                    if (i_byte[7]) begin
                        n_phase = PH_KEY;
                        n_cnt   = KEY_BYTES;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_XLEN: begin
                // top bit of a 64-bit length falls off the 63-bit register
                n_len = len_shift;
                if (r_cnt > 4'd1) begin
                    n_cnt = r_cnt - 4'd1;
                end else begin
                    hdr_len = len_shift;
                    if (r_flags[0]) begin
                        n_phase = PH_KEY;
                        n_cnt   = KEY_BYTES;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_byte};
                if (r_cnt > 4'd1) begin
                    n_cnt = r_cnt - 4'd1;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            PH_DATA: begin
                o_has_result       = 1'b1;
                o_result.kind      = KIND_PAYLOAD;
                o_result.fin       = r_flags[8];
                o_result.rsv_bits  = r_flags[7:5];
                o_result.opcode    = r_flags[4:1];
                o_result.masked    = r_flags[0];
                o_result.data_byte = i_byte ^ key_byte;
                o_result.last      = data_last;
                n_kidx = r_kidx + 2'd1;
                n_len  = data_last ? '0 : r_len - {{(LEN_W-1){1'b0}}, 1'b1};
                if (data_last) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                // first header byte; unused phase codes land here too
                n_flags = {i_byte[7], i_byte[6:4], i_byte[3:0], 1'b0};
                n_len   = '0;
                n_key   = '0;
                n_kidx  = 2'd0;
                n_cnt   = 4'd0;
                n_phase = PH_HDR1;
            end
        endcase

        if (hdr_done) begin
            o_has_result            = 1'b1;
            o_result.kind           = KIND_HEADER;
            o_result.fin            = n_flags[8];
            o_result.rsv_bits       = n_flags[7:5];
            o_result.opcode         = n_flags[4:1];
            o_result.masked         = n_flags[0];
            o_result.payload_length = hdr_len;
            o_result.last           = (hdr_len == '0);
            n_kidx  = 2'd0;
            n_cnt   = 4'd0;
            n_phase = (hdr_len == '0) ? PH_HDR0 : PH_DATA;
        end

        if (!i_valid) begin
            o_has_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_cnt   <= 4'd0;
            r_flags <= 9'd0;
            r_len   <= '0;
            r_key   <= 32'd0;
            r_kidx  <= 2'd0;
        end else if (i_commit) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_flags <= n_flags;
            r_len   <= n_len;
            r_key   <= n_key;
            r_kidx  <= n_kidx;
        end
    end

endmodule

### rtl/wsdf_out_reg.sv
// Result register on the output channel.
// Depends on wsdf_pkg.
module wsdf_out_reg
    import wsdf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // slot is free when empty or its transaction completes this edge
    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/websocket_frame_deframer_core.sv
// WebSocket (RFC 6455) receive deframer: takes one byte per transaction and
// emits one header result per frame plus one unmasked result per payload byte.
// A byte is held in the input register, is parsed, and lands in the result
// register; unless a stalled result holds it there, the block sustains one
// byte per cycle; the cycle is set by the 63-bit remaining-length decrement
// and zero test of the payload phase. Header, extended-length and key bytes
// produce no result and never wait on the output side, except the byte that
// completes the header: it carries the header result and, like a payload
// byte, waits while a stalled result still holds the result register.
`include "websocket_frame_deframer_core_defines.svh"

module websocket_frame_deframer_core
    import wsdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_in_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_kind,
    output logic             o_fin,
    output logic [2:0]       o_rsv_bits,
    output logic [3:0]       o_opcode,
    output logic             o_masked,
    output logic [LEN_W-1:0] o_payload_length,
    output logic [7:0]       o_data_byte,
    output logic             o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic    has_result;
    t_result parse_result;
    t_result out_result;
    logic    out_free;
    logic    consume;
    logic    out_load;
    logic    in_accept;

    assign consume    = r_in_valid && (!has_result || out_free);
    assign out_load   = consume && has_result;
    assign o_in_stall = r_in_valid && !consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    wsdf_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_commit     (consume),
        .i_byte       (r_in_byte),
        .o_has_result (has_result),
        .o_result     (parse_result)
    );

    wsdf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (parse_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_kind           = out_result.kind;
    assign o_fin            = out_result.fin;
    assign o_rsv_bits       = out_result.rsv_bits;
    assign o_opcode         = out_result.opcode;
    assign o_masked         = out_result.masked;
    assign o_payload_length = out_result.payload_length;
    assign o_data_byte      = out_result.data_byte;
    assign o_last           = out_result.last;

    // a held input byte is neither lost nor altered
    `WSDF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !consume,
        r_in_valid && (r_in_byte == $past(r_in_byte)))

    // a result is only loaded over an empty or departing one
    `WSDF_ASSERT_SAME(a_out_no_overwrite, i_clk, i_rst_n, out_load,
        !o_out_valid || !i_out_stall)

    // a stalled result is still there on the next edge
    `WSDF_ASSERT_NEXT(a_out_kept, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid)

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer_core: streams frame bytes
// with random gaps against random output stalls and checks every result against
// a built-in deframer model. Depends on wsdf_pkg and the core RTL only.
module testbench;
    import wsdf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 850;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 50;

    // length encodings of header byte two
    localparam int FORM_LEN7  = 0;
    localparam int FORM_LEN16 = 1;
    localparam int FORM_LEN64 = 2;

    // output stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_PERIOD = 3;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_in_byte = 8'd0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_kind;
    logic             o_fin;
    logic [2:0]       o_rsv_bits;
    logic [3:0]       o_opcode;
    logic             o_masked;
    logic [LEN_W-1:0] o_payload_length;
    logic [7:0]       o_data_byte;
    logic             o_last;

    websocket_frame_deframer_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_fin            (o_fin),
        .o_rsv_bits       (o_rsv_bits),
        .o_opcode         (o_opcode),
        .o_masked         (o_masked),
        .o_payload_length (o_payload_length),
        .o_data_byte      (o_data_byte),
        .o_last           (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    int          cycle_count = 0;
    int          err_count   = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          stall_mode  = STALL_NONE;
    int          stall_left  = 0;
    t_result     pending_results[$];
    t_result     want_r;

    // deframer state mirror
    logic [2:0]  st_phase = PH_HDR0;
    logic [3:0]  st_count = '0;
    logic        st_fin   = 1'b0;
    logic [2:0]  st_rsv   = '0;
    logic [3:0]  st_opc   = '0;
    logic        st_mask  = 1'b0;
    logic [63:0] st_len   = '0;
    logic [31:0] st_key   = '0;
    logic [1:0]  st_kidx  = '0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic header_done();
        t_result r;
        r                = '0;
        r.kind           = KIND_HEADER;
        r.fin            = st_fin;
        r.rsv_bits       = st_rsv;
        r.opcode         = st_opc;
        r.masked         = st_mask;
        r.payload_length = st_len[LEN_W-1:0];
        r.last           = (st_len == 0);
        st_kidx  = '0;
        st_count = '0;
        st_phase = (st_len == 0) ? PH_HDR0 : PH_DATA;
        pending_results.push_back(r);
    endtask

    task automatic length_done();
        if (st_mask) begin
            st_phase = PH_KEY;
            st_count = KEY_BYTES;
        end else begin
            header_done();
        end
    endtask

    task automatic predict_deframe(input logic [7:0] b);
        t_result    r;
        logic [7:0] kb;
        case (st_phase)
            PH_HDR1: begin
                st_mask = b[7];
                if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
                    st_len   = '0;
                    st_count = (b[6:0] == LEN7_EXT16) ? XLEN16_BYTES : XLEN64_BYTES;
                    st_phase = PH_XLEN;
                end else begin
                    st_len = {57'd0, b[6:0]};
                    length_done();
                end
            end
            PH_XLEN: begin
                st_len = {st_len[55:0], b};
                if (st_count > 1) begin
                    st_count--;
                end else begin
                    st_len[63] = 1'b0;
                    length_done();
                end
            end
            PH_KEY: begin
                st_key = {st_key[23:0], b};
                if (st_count > 1)
                    st_count--;
                else
                    header_done();
            end
            PH_DATA: begin
                kb = st_key[31 - 8*st_kidx -: 8];
                r           = '0;
                r.kind      = KIND_PAYLOAD;
                r.fin       = st_fin;
                r.rsv_bits  = st_rsv;
                r.opcode    = st_opc;
                r.masked    = st_mask;
                r.data_byte = b ^ kb;
                st_kidx++;
                if (st_len > 0)
                    st_len--;
                r.last = (st_len == 0);
                if (st_len == 0)
                    st_phase = PH_HDR0;
                pending_results.push_back(r);
            end
            default: begin
                st_fin   = b[7];
                st_rsv   = b[6:4];
                st_opc   = b[3:0];
                st_mask  = 1'b0;
                st_len   = '0;
                st_key   = '0;
                st_kidx  = '0;
                st_count = '0;
                st_phase = PH_HDR1;
            end
        endcase
    endtask

    // one byte transaction; a new burst may open with an idle gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        predict_deframe(b);
        items_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_frame(input logic [7:0] hdr0, input logic mask_on, input int form,
                              input logic [63:0] len, input int unsigned n_data);
        logic [31:0] key;
        key = $urandom;
        send_byte(hdr0);
        case (form)
            FORM_LEN16: begin
                send_byte({mask_on, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            FORM_LEN64: begin
                send_byte({mask_on, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default: send_byte({mask_on, len[6:0]});
        endcase
        if (mask_on)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8*i +: 8]);
        for (int unsigned i = 0; i < n_data; i++)
            send_byte(8'($urandom));
    endtask

    // empty frames, all header flags, non-minimal and top-bit-set lengths
    task automatic test_directed_frames();
        send_frame(8'h00, 1'b0, FORM_LEN7, 64'd0, 0);
        send_frame(8'hFF, 1'b1, FORM_LEN16, 64'd0, 0);
        send_frame(8'h81, 1'b0, FORM_LEN7, 64'd3, 3);
        send_frame(8'h4A, 1'b1, FORM_LEN64, 64'h8000_0000_0000_0004, 4);
    endtask

    task automatic test_random_frames();
        int          pick;
        int          form;
        int unsigned nlen;
        logic [63:0] len;
        logic [3:0]  opc;
        opc = '0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                form = FORM_LEN7;
                nlen = ($urandom_range(0, 15) == 0) ? 125 : $urandom_range(0, 12);
            end else if (pick < 8) begin
                form = FORM_LEN16;
                nlen = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 260)
                                                   : $urandom_range(0, 20);
            end else begin
                form = FORM_LEN64;
                nlen = $urandom_range(0, 20);
            end
            len = 64'(nlen);
            if (form == FORM_LEN64)
                len[63] = 1'($urandom_range(0, 1));
            send_frame({4'($urandom), opc}, 1'($urandom_range(0, 1)), form, len, nlen);
            opc++;
        end
    endtask

    // all-ones 64-bit length: the block stays in payload, so this runs last
    task automatic test_max_length();
        send_frame(8'h82, 1'b1, FORM_LEN64, '1, 9);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern, switching mode every so often
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_PERIOD);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIOD: i_out_stall <= (cycle_count % 8 < 3);
            default:      i_out_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", {63'd0, o_kind}, 64'd0);
            end else begin
                want_r = pending_results.pop_front();
                if (o_kind !== want_r.kind)
                    report_mismatch("kind", 64'(o_kind), 64'(want_r.kind));
                if (o_fin !== want_r.fin)
                    report_mismatch("fin", 64'(o_fin), 64'(want_r.fin));
                if (o_rsv_bits !== want_r.rsv_bits)
                    report_mismatch("rsv_bits", 64'(o_rsv_bits), 64'(want_r.rsv_bits));
                if (o_opcode !== want_r.opcode)
                    report_mismatch("opcode", 64'(o_opcode), 64'(want_r.opcode));
                if (o_masked !== want_r.masked)
                    report_mismatch("masked", 64'(o_masked), 64'(want_r.masked));
                if (o_payload_length !== want_r.payload_length)
                    report_mismatch("payload_length", 64'(o_payload_length),
                                    64'(want_r.payload_length));
                if (o_data_byte !== want_r.data_byte)
                    report_mismatch("data_byte", 64'(o_data_byte), 64'(want_r.data_byte));
                if (o_last !== want_r.last)
                    report_mismatch("last", 64'(o_last), 64'(want_r.last));
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_random_frames();
        test_max_length();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
